@@ design/lrmt_pkg.sv @@
// shared types, constants and helpers for the lazy range add / range min tree
`default_nettype none
package lrmt_pkg;

    localparam int ENTRIES_DEF = 1024;
    localparam int LEN_W       = 11;
    localparam int IDX_W       = 10;
    localparam int ADD_W       = 32;
    localparam int VAL_W       = 48;
    localparam int WIDE_W      = 17;

    localparam logic [LEN_W-1:0]        LEN_RESET = 11'd1024;
    localparam logic signed [VAL_W-1:0] EMPTY_MIN = 48'sd2147483647;

    typedef enum logic [1:0] {
        PH_ENTER,
        PH_LEFT,
        PH_RIGHT
    } t_phase;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_CLEAR,
        CMD_ACCEPT,
        CMD_ROOT,
        CMD_RET_NONE,
        CMD_RD_MIN,
        CMD_RD_BOTH,
        CMD_RD_PEND,
        CMD_QTAKE,
        CMD_GIVE_W,
        CMD_DESCEND_L,
        CMD_DESCEND_R,
        CMD_PUSH_RD_L,
        CMD_PUSH_L,
        CMD_PUSH_R,
        CMD_PUSH_CLR,
        CMD_COMBINE,
        CMD_PULL_RD_L,
        CMD_PULL_RD_R,
        CMD_PULL_W,
        CMD_POP,
        CMD_EMIT
    } t_cmd;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_VISIT,
        S_QTAKE,
        S_GIVE,
        S_PCHK,
        S_PUSHL,
        S_PUSHR,
        S_PCLR,
        S_PULLR,
        S_PULLW,
        S_RET,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic   clear_done;
        logic   empty;
        logic   is_query;
        logic   disjoint;
        logic   covered;
        logic   pend_zero;
        logic   sp_zero;
        logic   out_free;
        t_phase phase;
    } t_status;

    function automatic logic signed [VAL_W-1:0] sat_add(
        input logic signed [VAL_W-1:0] x,
        input logic signed [VAL_W-1:0] y
    );
        logic signed [VAL_W:0] s;
        s = {x[VAL_W-1], x} + {y[VAL_W-1], y};
        if (s[VAL_W] != s[VAL_W-1]) begin
            sat_add = s[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        end else begin
            sat_add = s[VAL_W-1:0];
        end
    endfunction

endpackage
`default_nettype wire

@@ design/lrmt_item_if.sv @@
// input channel: one operation beat
`default_nettype none
interface lrmt_item_if import lrmt_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    kind;
    logic [IDX_W-1:0]        lo_index;
    logic [IDX_W-1:0]        hi_index;
    logic signed [ADD_W-1:0] add_value;

    modport source (output valid, kind, lo_index, hi_index, add_value, input ready);
    modport sink   (input valid, kind, lo_index, hi_index, add_value, output ready);
endinterface
`default_nettype wire

@@ design/lrmt_result_if.sv @@
// output channel: one query result beat
`default_nettype none
interface lrmt_result_if import lrmt_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] min_value;
    logic                    empty_range;

    modport source (output valid, min_value, empty_range, input ready);
    modport sink   (input valid, min_value, empty_range, output ready);
endinterface
`default_nettype wire

@@ design/lrmt_dpath.sv @@
// datapath: tree memories, traversal stack, config register and result register
`default_nettype none
module lrmt_dpath import lrmt_pkg::*; #(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_cmd                    i_cmd,
    output t_status                      o_status,
    input  wire logic                    i_cfg_wr_en,
    input  wire logic [LEN_W-1:0]        i_cfg_wr_data,
    input  wire logic                    i_kind,
    input  wire logic [IDX_W-1:0]        i_lo_index,
    input  wire logic [IDX_W-1:0]        i_hi_index,
    input  wire logic signed [ADD_W-1:0] i_add_value,
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output logic signed [VAL_W-1:0]      o_min_value,
    output logic                         o_empty_range
);

    localparam int IW  = $clog2(ENTRIES);
    localparam int AW  = IW + 1;
    localparam int PW  = AW - 1;
    localparam int SD  = AW;
    localparam int SPW = (SD > 1) ? $clog2(SD) : 1;
    localparam logic [WIDE_W-1:0] NUM_W   = WIDE_W'(ENTRIES);
    localparam logic [IW-1:0]     LAST_IX = IW'(ENTRIES - 1);

    logic signed [VAL_W-1:0] r_min_mem [2**AW];
    logic signed [VAL_W-1:0] r_pnd_mem [2**PW];
    logic signed [VAL_W-1:0] r_min_q;
    logic signed [VAL_W-1:0] r_pnd_q;

    logic [AW-1:0]           r_st_node [SD];
    logic [IW-1:0]           r_st_lo   [SD];
    logic [IW-1:0]           r_st_hi   [SD];
    t_phase                  r_st_ph   [SD];
    logic                    r_st_have [SD];
    logic signed [VAL_W-1:0] r_st_val  [SD];

    logic [SPW-1:0]          r_sp;
    logic [AW-1:0]           r_clr_addr;
    logic [LEN_W-1:0]        r_used_length;
    logic                    r_kind;
    logic                    r_empty;
    logic [WIDE_W-1:0]       r_a;
    logic [WIDE_W-1:0]       r_b;
    logic signed [VAL_W-1:0] r_amt;
    logic signed [VAL_W-1:0] r_push;
    logic signed [VAL_W-1:0] r_left;
    logic                    r_ret_have;
    logic signed [VAL_W-1:0] r_ret_val;
    logic                    r_out_valid;
    logic signed [VAL_W-1:0] r_out_val;
    logic                    r_out_empty;

    logic [AW-1:0]     cur_node;
    logic [IW-1:0]     cur_lo;
    logic [IW-1:0]     cur_hi;
    logic [IW:0]       mid_sum;
    logic [IW-1:0]     mid;
    logic [IW-1:0]     mid_p1;
    logic [AW-1:0]     left_node;
    logic [AW-1:0]     right_node;
    logic              left_leaf;
    logic              right_leaf;
    logic [WIDE_W-1:0] lo_w;
    logic [WIDE_W-1:0] hi_w;
    logic [WIDE_W-1:0] len;
    logic [WIDE_W-1:0] a_in;
    logic [WIDE_W-1:0] b_in;
    logic [WIDE_W-1:0] b_clip;
    logic              empty_in;

    logic                    min_we;
    logic [AW-1:0]           min_waddr;
    logic signed [VAL_W-1:0] min_wdata;
    logic [AW-1:0]           min_raddr;
    logic                    pnd_we;
    logic [PW-1:0]           pnd_waddr;
    logic signed [VAL_W-1:0] pnd_wdata;
    logic [PW-1:0]           pnd_raddr;

    logic                    cmb_have;
    logic signed [VAL_W-1:0] cmb_val;

    assign cur_node   = r_st_node[r_sp];
    assign cur_lo     = r_st_lo[r_sp];
    assign cur_hi     = r_st_hi[r_sp];
    assign mid_sum    = {1'b0, cur_lo} + {1'b0, cur_hi};
    assign mid        = mid_sum[IW:1];
    assign mid_p1     = mid + 1'b1;
    assign left_node  = {cur_node[AW-2:0], 1'b0};
    assign right_node = {cur_node[AW-2:0], 1'b1};
    assign left_leaf  = (cur_lo == mid);
    assign right_leaf = (mid_p1 == cur_hi);
    assign lo_w       = WIDE_W'(cur_lo);
    assign hi_w       = WIDE_W'(cur_hi);

    // bound clipping at accept
    always_comb begin
        len      = (WIDE_W'(r_used_length) < NUM_W) ? WIDE_W'(r_used_length) : NUM_W;
        a_in     = WIDE_W'(i_lo_index);
        b_in     = WIDE_W'(i_hi_index);
        b_clip   = (len != '0 && b_in > len - 1'b1) ? len - 1'b1 : b_in;
        empty_in = (len == '0) || (a_in >= len) || (a_in > b_clip);
    end

    always_comb begin
        cmb_have = r_ret_have;
        cmb_val  = r_ret_val;
        if (r_st_have[r_sp]) begin
            cmb_have = 1'b1;
            if (!r_ret_have || r_st_val[r_sp] < r_ret_val) begin
                cmb_val = r_st_val[r_sp];
            end
        end
    end

    always_comb begin
        min_we    = 1'b0;
        min_waddr = cur_node;
        min_wdata = '0;
        min_raddr = cur_node;
        pnd_we    = 1'b0;
        pnd_waddr = cur_node[PW-1:0];
        pnd_wdata = '0;
        pnd_raddr = cur_node[PW-1:0];
        unique case (i_cmd)
            CMD_CLEAR: begin
                min_we    = 1'b1;
                min_waddr = r_clr_addr;
                pnd_we    = 1'b1;
                pnd_waddr = r_clr_addr[PW-1:0];
            end
            CMD_GIVE_W: begin
                min_we    = 1'b1;
                min_wdata = sat_add(r_min_q, r_amt);
                pnd_we    = (cur_lo != cur_hi);
                pnd_wdata = sat_add(r_pnd_q, r_amt);
            end
            CMD_PUSH_RD_L, CMD_PULL_RD_L: begin
                min_raddr = left_node;
                pnd_raddr = left_node[PW-1:0];
            end
            CMD_PUSH_L: begin
                min_we    = 1'b1;
                min_waddr = left_node;
                min_wdata = sat_add(r_min_q, r_push);
                pnd_we    = !left_leaf;
                pnd_waddr = left_node[PW-1:0];
                pnd_wdata = sat_add(r_pnd_q, r_push);
                min_raddr = right_node;
                pnd_raddr = right_node[PW-1:0];
            end
            CMD_PUSH_R: begin
                min_we    = 1'b1;
                min_waddr = right_node;
                min_wdata = sat_add(r_min_q, r_push);
                pnd_we    = !right_leaf;
                pnd_waddr = right_node[PW-1:0];
                pnd_wdata = sat_add(r_pnd_q, r_push);
            end
            CMD_PULL_RD_R: begin
                min_raddr = right_node;
            end
            CMD_PUSH_CLR: begin
                pnd_we = 1'b1;
            end
            CMD_PULL_W: begin
                min_we    = 1'b1;
                min_wdata = (r_left < r_min_q) ? r_left : r_min_q;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (min_we) begin
            r_min_mem[min_waddr] <= min_wdata;
        end
        if (pnd_we) begin
            r_pnd_mem[pnd_waddr] <= pnd_wdata;
        end
        r_min_q <= r_min_mem[min_raddr];
        r_pnd_q <= r_pnd_mem[pnd_raddr];
    end

    // payload and stack
    always_ff @(posedge i_clk) begin
        unique case (i_cmd)
            CMD_ACCEPT: begin
                r_kind  <= i_kind;
                r_a     <= a_in;
                r_b     <= b_clip;
                r_empty <= empty_in;
                r_amt   <= VAL_W'(i_add_value);
            end
            CMD_ROOT: begin
                r_st_node[0] <= AW'(1);
                r_st_lo[0]   <= '0;
                r_st_hi[0]   <= LAST_IX;
                r_st_ph[0]   <= PH_ENTER;
            end
            CMD_RET_NONE: begin
                r_ret_have <= 1'b0;
            end
            CMD_QTAKE: begin
                r_ret_have <= 1'b1;
                r_ret_val  <= r_min_q;
            end
            CMD_COMBINE: begin
                r_ret_have <= cmb_have;
                r_ret_val  <= cmb_val;
            end
            CMD_DESCEND_L, CMD_PUSH_CLR: begin
                r_st_ph[r_sp]          <= PH_LEFT;
                r_st_node[r_sp + 1'b1] <= left_node;
                r_st_lo[r_sp + 1'b1]   <= cur_lo;
                r_st_hi[r_sp + 1'b1]   <= mid;
                r_st_ph[r_sp + 1'b1]   <= PH_ENTER;
            end
            CMD_DESCEND_R: begin
                r_st_ph[r_sp]          <= PH_RIGHT;
                r_st_have[r_sp]        <= r_ret_have;
                r_st_val[r_sp]         <= r_ret_val;
                r_st_node[r_sp + 1'b1] <= right_node;
                r_st_lo[r_sp + 1'b1]   <= mid_p1;
                r_st_hi[r_sp + 1'b1]   <= cur_hi;
                r_st_ph[r_sp + 1'b1]   <= PH_ENTER;
            end
            CMD_PUSH_RD_L: begin
                r_push <= r_pnd_q;
            end
            CMD_PULL_RD_R: begin
                r_left <= r_min_q;
            end
            CMD_EMIT: begin
                r_out_val   <= r_ret_have ? r_ret_val : EMPTY_MIN;
                r_out_empty <= !r_ret_have;
            end
            default: begin
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp          <= '0;
            r_clr_addr    <= '0;
            r_used_length <= LEN_RESET;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_used_length <= i_cfg_wr_data;
            end
            if (i_cmd == CMD_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd == CMD_ROOT) begin
                r_sp <= '0;
            end else if (i_cmd == CMD_DESCEND_L || i_cmd == CMD_DESCEND_R
                         || i_cmd == CMD_PUSH_CLR) begin
                r_sp <= r_sp + 1'b1;
            end else if (i_cmd == CMD_POP) begin
                r_sp <= r_sp - 1'b1;
            end
            if (i_cmd == CMD_EMIT) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.clear_done = &r_clr_addr;
    assign o_status.empty      = r_empty;
    assign o_status.is_query   = r_kind;
    assign o_status.disjoint   = (r_a > hi_w) || (r_b < lo_w);
    assign o_status.covered    = (lo_w >= r_a) && (hi_w <= r_b);
    assign o_status.pend_zero  = (r_pnd_q == '0);
    assign o_status.sp_zero    = (r_sp == '0);
    assign o_status.out_free   = !r_out_valid || i_ready;
    assign o_status.phase      = r_st_ph[r_sp];

    assign o_valid       = r_out_valid;
    assign o_min_value   = r_out_val;
    assign o_empty_range = r_out_empty;

endmodule
`default_nettype wire

@@ design/lrmt_ctrl.sv @@
// controller: sequences the tree walk one memory step at a time
`default_nettype none
module lrmt_ctrl import lrmt_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_item_valid,
    output logic         o_item_ready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_status.clear_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_item_valid) n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_status.empty) begin
                    n_state = i_status.is_query ? S_EMIT : S_IDLE;
                end else begin
                    n_state = S_VISIT;
                end
            end
            S_VISIT: begin
                unique case (i_status.phase)
                    PH_ENTER: begin
                        priority if (i_status.disjoint) n_state = S_RET;
                        else if (i_status.covered) begin
                            n_state = i_status.is_query ? S_QTAKE : S_GIVE;
                        end else n_state = S_PCHK;
                    end
                    PH_LEFT:  n_state = S_VISIT;
                    PH_RIGHT: n_state = i_status.is_query ? S_RET : S_PULLR;
                    default:  n_state = S_VISIT;
                endcase
            end
            S_QTAKE: n_state = S_RET;
            S_GIVE:  n_state = S_RET;
            S_PCHK:  n_state = i_status.pend_zero ? S_VISIT : S_PUSHL;
            S_PUSHL: n_state = S_PUSHR;
            S_PUSHR: n_state = S_PCLR;
            S_PCLR:  n_state = S_VISIT;
            S_PULLR: n_state = S_PULLW;
            S_PULLW: n_state = S_RET;
            S_RET: begin
                if (i_status.sp_zero) begin
                    n_state = i_status.is_query ? S_EMIT : S_IDLE;
                end else begin
                    n_state = S_VISIT;
                end
            end
            S_EMIT: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd        = CMD_NONE;
        o_item_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: o_cmd = CMD_CLEAR;
            S_IDLE: begin
                o_item_ready = 1'b1;
                if (i_item_valid) o_cmd = CMD_ACCEPT;
            end
            S_CHECK: begin
                if (i_status.empty) o_cmd = CMD_RET_NONE;
                else o_cmd = CMD_ROOT;
            end
            S_VISIT: begin
                unique case (i_status.phase)
                    PH_ENTER: begin
                        priority if (i_status.disjoint) o_cmd = CMD_RET_NONE;
                        else if (i_status.covered) begin
                            o_cmd = i_status.is_query ? CMD_RD_MIN : CMD_RD_BOTH;
                        end else o_cmd = CMD_RD_PEND;
                    end
                    PH_LEFT:  o_cmd = CMD_DESCEND_R;
                    PH_RIGHT: o_cmd = i_status.is_query ? CMD_COMBINE : CMD_PULL_RD_L;
                    default:  o_cmd = CMD_NONE;
                endcase
            end
            S_QTAKE: o_cmd = CMD_QTAKE;
            S_GIVE:  o_cmd = CMD_GIVE_W;
            S_PCHK:  o_cmd = i_status.pend_zero ? CMD_DESCEND_L : CMD_PUSH_RD_L;
            S_PUSHL: o_cmd = CMD_PUSH_L;
            S_PUSHR: o_cmd = CMD_PUSH_R;
            S_PCLR:  o_cmd = CMD_PUSH_CLR;
            S_PULLR: o_cmd = CMD_PULL_RD_R;
            S_PULLW: o_cmd = CMD_PULL_W;
            S_RET: begin
                if (!i_status.sp_zero) o_cmd = CMD_POP;
            end
            S_EMIT: begin
                if (i_status.out_free) o_cmd = CMD_EMIT;
            end
            default: o_cmd = CMD_NONE;
        endcase
    end

endmodule
`default_nettype wire

@@ design/lazy_range_add_min_tree_core.sv @@
// top level of the lazy range add / range minimum tree
// Keeps ENTRIES signed 48-bit elements in a lazy segment tree held in two memories with one
// read and one write port each (node minima, pending adds of inner nodes); a range add beat
// returns nothing, a range minimum beat returns one result beat. After reset a clearing pass
// zeroes the memories while no beat is taken. One operation then walks the tree depth first,
// one memory step per cycle, and the input stays stalled until the operation ends: the beat
// is taken and checked, then a visited node outside the range is left at once, a covered
// node is read (and updated by an add), and a split node has any pending add pushed down to
// both children before the walk descends left, then right, and (add) pulls the children's
// minima back up. A query then hands its result to the output register, waiting while an
// earlier result is not yet taken. A new beat is taken while an earlier result waits.
`default_nettype none
module lazy_range_add_min_tree_core import lrmt_pkg::*; #(
    parameter int ENTRIES = ENTRIES_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_wr_en,
    input  wire logic [LEN_W-1:0] i_cfg_wr_data,
    lrmt_item_if.sink             i_item,
    lrmt_result_if.source         o_result
);

    t_cmd    cmd;
    t_status status;
    logic    item_ready;

    lrmt_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (i_item.valid),
        .o_item_ready (item_ready),
        .i_status     (status),
        .o_cmd        (cmd)
    );

    lrmt_dpath #(
        .ENTRIES (ENTRIES)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_kind        (i_item.kind),
        .i_lo_index    (i_item.lo_index),
        .i_hi_index    (i_item.hi_index),
        .i_add_value   (i_item.add_value),
        .o_valid       (o_result.valid),
        .i_ready       (o_result.ready),
        .o_min_value   (o_result.min_value),
        .o_empty_range (o_result.empty_range)
    );

    assign i_item.ready = item_ready;

endmodule
`default_nettype wire
